>>> sv/mtp_pkg.sv
// Shared types and constants for the MT19937 generator.
package mtp_pkg;
  localparam logic [31:0] INIT_MULT    = 32'd1812433253;
  localparam logic [31:0] TWIST_MATRIX = 32'h9908b0df;
  localparam logic [31:0] HIGH_BIT     = 32'h80000000;
  localparam logic [31:0] LOW_BITS     = 32'h7fffffff;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc60000;
  localparam logic [31:0] ALL_ONES     = 32'hffffffff;

  typedef enum logic [1:0] {
    OP_RAW    = 2'd0,
    OP_BOUND  = 2'd1,
    OP_RESEED = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    ST_SEED,      // linear init sweep, one word per cycle
    ST_IDLE,
    ST_TW_RD0,    // prime the twist: read word 0
    ST_TW_RUN,    // one word per cycle
    ST_RD,        // read issued for current word
    ST_TEMPER,
    ST_CHECK,
    ST_DIV,       // shared restoring divider
    ST_DIVW,
    ST_LIMIT,
    ST_MOD,
    ST_OUT
  } state_t;

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction
endpackage

>>> sv/mtp_ram.sv
// Generic single-port-write, dual-read RAM with registered read.
module mtp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

>>> sv/mtp_div.sv
// 32-bit unsigned restoring divider, one quotient bit per cycle.
module mtp_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] remainder
);
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt, quo_r, quo_nxt, dvs_r, dvs_nxt;
  logic        busy_r, busy_nxt;
  logic [32:0] trial;

  always_comb begin
    cnt_nxt = cnt_r; rem_nxt = rem_r; quo_nxt = quo_r;
    dvs_nxt = dvs_r; busy_nxt = busy_r;
    trial = {rem_r, quo_r[31]} - {1'b0, dvs_r};
    if (start) begin
      busy_nxt = 1'b1; cnt_nxt = 6'd32; rem_nxt = '0;
      quo_nxt = dividend; dvs_nxt = divisor;
    end else if (busy_r) begin
      if (!trial[32]) rem_nxt = trial[31:0];
      else            rem_nxt = {rem_r[30:0], quo_r[31]};
      quo_nxt = {quo_r[30:0], 1'b0};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = busy_r && (cnt_r == 6'd1);
  assign remainder = !trial[32] ? trial[31:0] : {rem_r[30:0], quo_r[31]};
endmodule

>>> sv/mersenne_twister_prng.sv
// Top level of the MT19937-32 generator.
// MT19937-32 generator with the 624-word state in one RAM (two registered
// read ports, one write port). A raw word is read in ST_RD, tempered in
// ST_TEMPER, checked in ST_CHECK and presented in ST_OUT when no twist is
// due; every 624th word first runs a twist pass (one word per cycle through
// the RAM). A reseed, and the self-seeding after reset, sweep the RAM through
// the init multiplier, with no input accepted meanwhile. A bounded draw adds
// the final modulo on the divider (one remainder bit per cycle) and, for
// spans up to 2^31, a limit division before the draw (skipped for wider
// spans); each rejected draw goes back for a new word. One item is in work at
// a time and the input stays closed until its result has been taken.
module mersenne_twister_prng #(
  parameter int STATE_WORDS = 624,
  parameter int SHIFT_OFFSET = 397
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_seed_value,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic signed [31:0] in_range_begin,
  input  logic signed [31:0] in_range_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_raw_word,
  output logic signed [31:0] out_bounded_value,
  output logic        out_bad_range,
  output logic        out_seeded
);
  localparam int AW = $clog2(STATE_WORDS + 1);
  localparam int MW = $clog2(STATE_WORDS);
  localparam logic [AW-1:0] LAST = AW'(STATE_WORDS - 1);
  localparam logic [AW-1:0] FULL = AW'(STATE_WORDS);

  mtp_pkg::state_t st_r, st_nxt;
  logic [31:0] seed_r;
  logic [AW-1:0] idx_r, idx_nxt, k_r, k_nxt;
  logic [31:0] prev_r, prev_nxt;
  logic [31:0] mult_r, mult_nxt;
  logic [1:0] op_r, op_nxt;
  logic [31:0] beg_r, beg_nxt, dist_r, dist_nxt, limit_r, limit_nxt;
  logic [31:0] word_r, word_nxt, cur_r, cur_nxt;
  logic        ov_r, ov_nxt;
  logic [31:0] o_raw_r, o_raw_nxt, o_bv_r, o_bv_nxt;
  logic        o_bad_r, o_bad_nxt, o_sd_r, o_sd_nxt;

  logic          we;
  logic [MW-1:0] waddr, ra, rb;
  logic [31:0]   wdata, rda, rdb;
  logic          dstart, ddone;
  logic [31:0]   ddvd, drem;
  logic [31:0]   y, mix, left;

  mtp_ram #(.WIDTH(32), .DEPTH(STATE_WORDS)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr_a(ra), .rdata_a(rda), .raddr_b(rb), .rdata_b(rdb));

  mtp_div u_div (.clk, .rst_n, .start(dstart), .dividend(ddvd), .divisor(dist_r),
    .done(ddone), .remainder(drem));

  function automatic logic [MW-1:0] wrapi(input logic [AW:0] v);
    return (v >= (AW+1)'(STATE_WORDS)) ? MW'(v - (AW+1)'(STATE_WORDS)) : MW'(v);
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = (st_r == mtp_pkg::ST_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_raw_word = o_raw_r;
  assign out_bounded_value = o_bv_r;
  assign out_bad_range = o_bad_r;
  assign out_seeded = o_sd_r;

  // twist: cur_r holds word k, rda gives word k+1, rdb word k+397
  assign y = (cur_r & mtp_pkg::HIGH_BIT) | (rda & mtp_pkg::LOW_BITS);
  assign mix = rdb ^ (y >> 1) ^ (y[0] ? mtp_pkg::TWIST_MATRIX : 32'd0);
  assign left = {drem[30:0], 1'b0} >= dist_r ? {drem[30:0], 1'b0} - dist_r
                                             : {drem[30:0], 1'b0};

  always_comb begin
    case (st_r)
      mtp_pkg::ST_SEED:   st_nxt = (k_r == LAST) ? mtp_pkg::ST_IDLE : mtp_pkg::ST_SEED;
      mtp_pkg::ST_IDLE: begin
        st_nxt = mtp_pkg::ST_IDLE;
        if (in_valid && in_ready) begin
          case (in_operation)
            mtp_pkg::OP_RAW:
              st_nxt = (idx_r >= FULL) ? mtp_pkg::ST_TW_RD0 : mtp_pkg::ST_RD;
            mtp_pkg::OP_BOUND:
              st_nxt = (in_range_end <= in_range_begin) ? mtp_pkg::ST_OUT
                     : ((in_range_end - in_range_begin) <= mtp_pkg::HIGH_BIT)
                       ? mtp_pkg::ST_DIV : mtp_pkg::ST_LIMIT;
            mtp_pkg::OP_RESEED: st_nxt = mtp_pkg::ST_SEED;
            default: st_nxt = mtp_pkg::ST_OUT;
          endcase
        end
      end
      mtp_pkg::ST_DIV:    st_nxt = mtp_pkg::ST_DIVW;
      mtp_pkg::ST_DIVW:   st_nxt = ddone ? mtp_pkg::ST_LIMIT : mtp_pkg::ST_DIVW;
      mtp_pkg::ST_LIMIT:  st_nxt = (idx_r >= FULL) ? mtp_pkg::ST_TW_RD0 : mtp_pkg::ST_RD;
      mtp_pkg::ST_TW_RD0: st_nxt = mtp_pkg::ST_TW_RUN;
      mtp_pkg::ST_TW_RUN: st_nxt = (k_r == LAST) ? mtp_pkg::ST_RD : mtp_pkg::ST_TW_RUN;
      mtp_pkg::ST_RD:     st_nxt = mtp_pkg::ST_TEMPER;
      mtp_pkg::ST_TEMPER: st_nxt = mtp_pkg::ST_CHECK;
      mtp_pkg::ST_CHECK: begin
        if (op_r == mtp_pkg::OP_RAW) st_nxt = mtp_pkg::ST_OUT;
        else if (word_r > limit_r)
          st_nxt = (idx_r >= FULL) ? mtp_pkg::ST_TW_RD0 : mtp_pkg::ST_RD;
        else st_nxt = mtp_pkg::ST_MOD;
      end
      mtp_pkg::ST_MOD:    st_nxt = ddone ? mtp_pkg::ST_OUT : mtp_pkg::ST_MOD;
      mtp_pkg::ST_OUT:    st_nxt = ov_r ? mtp_pkg::ST_OUT : mtp_pkg::ST_IDLE;
      default:            st_nxt = mtp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    idx_nxt = idx_r; k_nxt = k_r; prev_nxt = prev_r; mult_nxt = mult_r;
    op_nxt = op_r; beg_nxt = beg_r; dist_nxt = dist_r; limit_nxt = limit_r;
    word_nxt = word_r; cur_nxt = cur_r; ov_nxt = ov_r;
    o_raw_nxt = o_raw_r; o_bv_nxt = o_bv_r; o_bad_nxt = o_bad_r; o_sd_nxt = o_sd_r;
    we = 1'b0; waddr = '0; wdata = prev_r; ra = MW'(idx_r); rb = '0;
    dstart = 1'b0; ddvd = mtp_pkg::HIGH_BIT;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (st_r)
      mtp_pkg::ST_SEED: begin
        // prev_r is word k-1, mult_r its registered product term
        we = 1'b1; waddr = MW'(k_r);
        wdata = (k_r == '0) ? seed_r : mult_r + 32'(k_r);
        prev_nxt = wdata;
        mult_nxt = mtp_pkg::INIT_MULT * (wdata ^ (wdata >> 30));
        k_nxt = k_r + AW'(1);
        if (k_r == LAST) idx_nxt = FULL;
      end
      mtp_pkg::ST_IDLE: begin
        op_nxt = in_operation; beg_nxt = in_range_begin;
        dist_nxt = in_range_end - in_range_begin;
        limit_nxt = dist_nxt - 32'd1;
        k_nxt = '0;
      end
      mtp_pkg::ST_DIV: dstart = 1'b1;
      mtp_pkg::ST_DIVW: if (ddone) limit_nxt = mtp_pkg::ALL_ONES - left;
      mtp_pkg::ST_TW_RD0: begin
        ra = '0; k_nxt = '0;
      end
      mtp_pkg::ST_TW_RUN: begin
        // first cycle: rda holds word 0; from then on cur_r is word k
        if (!prev_r[0]) begin
          cur_nxt = rda; prev_nxt = 32'd1;
          ra = MW'(1); rb = MW'(SHIFT_OFFSET);
        end else begin
          we = 1'b1; waddr = MW'(k_r); wdata = mix;
          cur_nxt = rda;
          k_nxt = k_r + AW'(1);
          ra = wrapi({1'b0, k_r} + (AW+1)'(2));
          rb = wrapi({1'b0, k_r} + (AW+1)'(SHIFT_OFFSET + 1));
          if (k_r == LAST) begin
            idx_nxt = '0; prev_nxt = 32'd0;
          end
        end
      end
      mtp_pkg::ST_RD: ra = MW'(idx_r);
      mtp_pkg::ST_TEMPER: begin
        word_nxt = mtp_pkg::temper(rda);
        idx_nxt = idx_r + AW'(1);
      end
      mtp_pkg::ST_CHECK: begin
        if (op_r == mtp_pkg::OP_BOUND && word_r <= limit_r) begin
          dstart = 1'b1; ddvd = word_r;
        end
      end
      default: ;
    endcase
    if (st_r == mtp_pkg::ST_TW_RD0) prev_nxt = 32'd0;
    if (st_nxt == mtp_pkg::ST_OUT && st_r != mtp_pkg::ST_OUT) begin
      ov_nxt = 1'b1;
      o_raw_nxt = '0; o_bv_nxt = '0; o_bad_nxt = 1'b0; o_sd_nxt = 1'b0;
      if (st_r == mtp_pkg::ST_IDLE) begin
        if (in_operation == mtp_pkg::OP_BOUND) begin
          o_bv_nxt = in_range_begin; o_bad_nxt = 1'b1;
        end
      end else if (st_r == mtp_pkg::ST_MOD) o_bv_nxt = beg_r + drem;
      else o_raw_nxt = word_r;
    end
    if (st_r == mtp_pkg::ST_SEED && k_r == LAST && op_r == mtp_pkg::OP_RESEED) begin
      ov_nxt = 1'b1;
      o_raw_nxt = '0; o_bv_nxt = '0; o_bad_nxt = 1'b0; o_sd_nxt = 1'b1;
      op_nxt = mtp_pkg::OP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= mtp_pkg::ST_SEED;
      seed_r <= 32'd5489;
      idx_r  <= FULL;
      k_r    <= '0;
      ov_r   <= 1'b0;
      op_r   <= mtp_pkg::OP_NONE;
      prev_r <= '0;
    end else begin
      st_r  <= st_nxt;
      if (cfg_valid && cfg_ready) seed_r <= cfg_seed_value;
      idx_r <= idx_nxt;
      k_r   <= k_nxt;
      ov_r  <= ov_nxt;
      op_r  <= op_nxt;
      prev_r <= prev_nxt;
    end
    mult_r <= mult_nxt; beg_r <= beg_nxt; dist_r <= dist_nxt;
    limit_r <= limit_nxt; word_r <= word_nxt; cur_r <= cur_nxt;
    o_raw_r <= o_raw_nxt; o_bv_r <= o_bv_nxt; o_bad_r <= o_bad_nxt; o_sd_r <= o_sd_nxt;
  end
endmodule
